### rtl/srmu_pkg.sv
// ----------------------------------------------------------------------------
// srmu_pkg
// Shared constants and helper functions for the sparse-table range-minimum
// unit: table geometry, item kind codes, signed minimum and floor log2.
// ----------------------------------------------------------------------------
package srmu_pkg;

    // Table geometry.
    localparam int MAX_ELEMENTS = 1024;
    localparam int LEVELS       = 11;
    localparam int POS_W        = $clog2(MAX_ELEMENTS);
    localparam int CNT_W        = $clog2(MAX_ELEMENTS + 1);
    localparam int SPAN_W       = CNT_W + 1;
    localparam int LVL_W        = $clog2(LEVELS);
    localparam int ADDR_W       = LVL_W + POS_W;
    localparam int TBL_DEPTH    = LEVELS << POS_W;
    localparam int DATA_W       = 64;
    localparam int KIND_W       = 2;

    // Item kind codes.
    localparam logic [KIND_W-1:0] KIND_APPEND = 2'd0;
    localparam logic [KIND_W-1:0] KIND_QUERY  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

    // Signed minimum of two 64-bit two's complement values.
    function automatic logic [DATA_W-1:0] smin(input logic [DATA_W-1:0] a,
                                               input logic [DATA_W-1:0] b);
        return ($signed(a) < $signed(b)) ? a : b;
    endfunction

    // Floor log2 of a nonzero length, clamped to the top table level.
    function automatic logic [LVL_W-1:0] floor_log2(input logic [CNT_W-1:0] x);
        logic [LVL_W-1:0] k;
        k = '0;
        for (int i = 0; i < CNT_W; i++) begin
            if (x[i]) begin
                k = LVL_W'(i);
            end
        end
        if (k > LVL_W'(LEVELS - 1)) begin
            k = LVL_W'(LEVELS - 1);
        end
        return k;
    endfunction

    // Table address of a level and a position.
    function automatic logic [ADDR_W-1:0] tbl_addr(input logic [LVL_W-1:0] lvl,
                                                   input logic [POS_W-1:0] pos);
        return {lvl, pos};
    endfunction

endpackage

### rtl/srmu_ram.sv
// ----------------------------------------------------------------------------
// srmu_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. Contents are undefined until written.
// ----------------------------------------------------------------------------
module srmu_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

### rtl/sparse_table_range_minimum_unit.sv
// ----------------------------------------------------------------------------
// sparse_table_range_minimum_unit
// Append at position p: writes level zero at the accepting edge, then stays busy
//   for levels 1 to min(floor(log2(p+1)), LEVELS-1), one table level per cycle
//   through the single RAM. Query: two RAM reads, merged in ST_QOUT; the result
//   is strobed as the unit returns to idle, a bad range in the cycle after the
//   accepting edge. Clear and unused kinds never make the unit busy. Synchronous
//   reset empties the store; the table needs no clearing pass. Results cannot be stalled.
// ----------------------------------------------------------------------------
module sparse_table_range_minimum_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [srmu_pkg::KIND_W-1:0]          i_kind,
    input  logic signed [srmu_pkg::DATA_W-1:0]   i_value,
    input  logic [9:0]                           i_left,
    input  logic [9:0]                           i_right,
    output logic                                 o_strobe,
    output logic signed [srmu_pkg::DATA_W-1:0]   o_minimum,
    output logic                                 o_range_error
);

    import srmu_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_APPEND,
        ST_QRD2,
        ST_QOUT
    } t_state;

    t_state              r_state, n_state;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [CNT_W-1:0]    r_base, n_base;
    logic [SPAN_W-1:0]   r_span, n_span;
    logic [LVL_W-1:0]    r_lvl, n_lvl;
    logic [DATA_W-1:0]   r_cur, n_cur;
    logic [LVL_W-1:0]    r_k, n_k;
    logic [POS_W-1:0]    r_start2, n_start2;
    logic                r_strobe, n_strobe;
    logic [DATA_W-1:0]   r_min, n_min;
    logic                r_err, n_err;

    logic                mem_we;
    logic [ADDR_W-1:0]   mem_waddr;
    logic [DATA_W-1:0]   mem_wdata;
    logic [ADDR_W-1:0]   mem_raddr;
    logic [DATA_W-1:0]   mem_rdata;

    logic                q_bad;
    logic [CNT_W-1:0]    q_len;
    logic [LVL_W-1:0]    q_k;
    logic [CNT_W-1:0]    q_end;
    logic [DATA_W-1:0]   a_min;
    logic [SPAN_W-1:0]   a_next_span;
    logic [CNT_W-1:0]    a_wpos;

    // Table storage: level-major, one entry per level and position.
    srmu_ram #(
        .WIDTH(DATA_W),
        .DEPTH(TBL_DEPTH)
    ) u_table (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_waddr(mem_waddr),
        .i_wdata(mem_wdata),
        .i_raddr(mem_raddr),
        .o_rdata(mem_rdata)
    );

    // Query decode: range check, block level and start of the second block.
    assign q_bad = (i_left > i_right) || (CNT_W'(i_right) >= r_count);
    assign q_len = CNT_W'(i_right) - CNT_W'(i_left) + CNT_W'(1);
    assign q_k   = floor_log2(q_len);
    assign q_end = CNT_W'(i_right) + CNT_W'(1) - (CNT_W'(1) << q_k);

    // Append step: the shared compare unit merges the stored half with the
    // half just built one level down.
    assign a_min       = smin(mem_rdata, r_cur);
    assign a_next_span = r_span << 1;
    assign a_wpos      = r_base - CNT_W'(r_span);

    // Sequencer next-state and RAM control.
    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_base    = r_base;
        n_span    = r_span;
        n_lvl     = r_lvl;
        n_cur     = r_cur;
        n_k       = r_k;
        n_start2  = r_start2;
        n_strobe  = 1'b0;
        n_min     = r_min;
        n_err     = r_err;
        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wdata = r_cur;
        mem_raddr = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    case (i_kind)
                        KIND_APPEND: begin
                            if (r_count < CNT_W'(MAX_ELEMENTS)) begin
                                mem_we    = 1'b1;
                                mem_waddr = tbl_addr('0, r_count[POS_W-1:0]);
                                mem_wdata = i_value;
                                n_cur     = i_value;
                                n_count   = r_count + CNT_W'(1);
                                n_base    = r_count + CNT_W'(1);
                                n_span    = SPAN_W'(2);
                                n_lvl     = LVL_W'(1);
                                if (r_count != '0) begin
                                    mem_raddr = tbl_addr('0,
                                        POS_W'(r_count - CNT_W'(1)));
                                    n_state   = ST_APPEND;
                                end
                            end
                        end
                        KIND_QUERY: begin
                            if (q_bad) begin
                                n_strobe = 1'b1;
                                n_min    = '0;
                                n_err    = 1'b1;
                            end else begin
                                mem_raddr = tbl_addr(q_k, i_left);
                                n_k       = q_k;
                                n_start2  = q_end[POS_W-1:0];
                                n_state   = ST_QRD2;
                            end
                        end
                        KIND_CLEAR: begin
                            n_count = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_APPEND: begin
                mem_we    = 1'b1;
                mem_waddr = tbl_addr(r_lvl, a_wpos[POS_W-1:0]);
                mem_wdata = a_min;
                n_cur     = a_min;
                if ((r_lvl < LVL_W'(LEVELS - 1)) &&
                    (a_next_span <= SPAN_W'(r_base))) begin
                    mem_raddr = tbl_addr(r_lvl,
                        POS_W'(r_base - CNT_W'(a_next_span)));
                    n_lvl     = r_lvl + LVL_W'(1);
                    n_span    = a_next_span;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_QRD2: begin
                mem_raddr = tbl_addr(r_k, r_start2);
                n_cur     = mem_rdata;
                n_state   = ST_QOUT;
            end
            ST_QOUT: begin
                n_min    = a_min;
                n_err    = 1'b0;
                n_strobe = 1'b1;
                n_state  = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_count  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_strobe <= n_strobe;
        end
        r_base   <= n_base;
        r_span   <= n_span;
        r_lvl    <= n_lvl;
        r_cur    <= n_cur;
        r_k      <= n_k;
        r_start2 <= n_start2;
        r_min    <= n_min;
        r_err    <= n_err;
    end

    assign busy          = (r_state != ST_IDLE);
    assign o_strobe      = r_strobe;
    assign o_minimum     = r_min;
    assign o_range_error = r_err;

    // A result beat only ever appears while the sequencer is idle.
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !busy)
        else $error("result beat while busy");

    // The stored count never passes the table size.
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_ELEMENTS))
        else $error("stored count overflow");

    // An error beat always carries a zero minimum.
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_range_error) |-> (o_minimum == '0))
        else $error("error beat with nonzero minimum");

    // Each level step merges a block that lies wholly inside the stored range.
    a_span_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_APPEND) |-> (r_span <= SPAN_W'(r_base)))
        else $error("append block runs past position zero");

    // An accepted query gives a beat next cycle or keeps the unit busy.
    a_query_prog: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_kind == KIND_QUERY) |=> (o_strobe || busy))
        else $error("accepted query lost");

endmodule

### sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for sparse_table_range_minimum_unit
// Drives append, query, clear and unused beats through the start/busy
// handshake and predicts every query answer from a local copy of the sparse
// table. Covers directed corner cases, random mixed traffic under several
// sender idle rates, and a full store with appends that must be dropped.
// ----------------------------------------------------------------------------
module testbench;

    import srmu_pkg::*;

    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 400000;
    localparam logic signed [DATA_W-1:0] MOST_NEGATIVE = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic signed [DATA_W-1:0] MOST_POSITIVE = {1'b0, {(DATA_W-1){1'b1}}};

    typedef struct packed {
        logic [DATA_W-1:0] minimum;
        logic              range_error;
    } t_range_answer;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n;
    logic                      start;
    logic                      busy;
    logic [KIND_W-1:0]         i_kind;
    logic signed [DATA_W-1:0]  i_value;
    logic [9:0]                i_left;
    logic [9:0]                i_right;
    logic                      o_strobe;
    logic signed [DATA_W-1:0]  o_minimum;
    logic                      o_range_error;

    // Local copy of the table and of the number of stored values.
    logic [DATA_W-1:0]         level_minima [LEVELS][MAX_ELEMENTS];
    int                        tracked_count;
    t_range_answer             expected_answers[$];

    int mismatch_count = 0;
    int cycle_count    = 0;
    int issued_count   = 0;
    int idle_pct       = 0;

    sparse_table_range_minimum_unit u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_kind        (i_kind),
        .i_value       (i_value),
        .i_left        (i_left),
        .i_right       (i_right),
        .o_strobe      (o_strobe),
        .o_minimum     (o_minimum),
        .o_range_error (o_range_error)
    );

    // Free-running clock with a 10 ns period.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Guard against a hung handshake or a missing answer.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic log_mismatch(input string what, input logic [DATA_W-1:0] want,
                                input logic [DATA_W-1:0] got);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("%0t: %s expected %0d, got %0d", $time, what,
                     $signed(want), $signed(got));
        end
    endtask

    // Applies one accepted beat to the local table and queues the answer
    // that a query beat must produce.
    task automatic update_range_minima(input logic [KIND_W-1:0] kind,
                                       input logic [DATA_W-1:0] value,
                                       input int left, input int right);
        int pos;
        int lvl;
        int first;
        int second;
        int span;
        logic signed [DATA_W-1:0] lo_half;
        logic signed [DATA_W-1:0] hi_half;
        t_range_answer answer;
        case (kind)
            KIND_APPEND: begin
                if (tracked_count < MAX_ELEMENTS) begin
                    pos = tracked_count;
                    level_minima[0][pos] = value;
                    // Fill every level whose block ends at the new position.
                    for (lvl = 1; lvl < LEVELS; lvl++) begin
                        if ((1 << lvl) > pos + 1) break;
                        first   = pos + 1 - (1 << lvl);
                        lo_half = level_minima[lvl-1][first];
                        hi_half = level_minima[lvl-1][first + (1 << (lvl - 1))];
                        level_minima[lvl][first] = (lo_half < hi_half) ? lo_half : hi_half;
                    end
                    tracked_count++;
                end
            end
            KIND_QUERY: begin
                if (left > right || right >= tracked_count) begin
                    answer.minimum     = '0;
                    answer.range_error = 1'b1;
                end else begin
                    span = right - left + 1;
                    lvl  = 0;
                    while (span > 1) begin
                        span = span >> 1;
                        lvl++;
                    end
                    if (lvl > LEVELS - 1) lvl = LEVELS - 1;
                    second  = right + 1 - (1 << lvl);
                    lo_half = level_minima[lvl][left];
                    hi_half = level_minima[lvl][second];
                    answer.minimum     = (lo_half < hi_half) ? lo_half : hi_half;
                    answer.range_error = 1'b0;
                end
                expected_answers.push_back(answer);
            end
            KIND_CLEAR: begin
                tracked_count = 0;
            end
            default: begin
            end
        endcase
    endtask

    // Checks each strobed answer, then records the beat accepted at this edge.
    always @(posedge i_clk) begin : scoreboard
        t_range_answer want;
        if (!i_rst_n) begin
            tracked_count = 0;
            expected_answers.delete();
        end else begin
            if (o_strobe) begin
                if (expected_answers.size() == 0) begin
                    log_mismatch("answer with no query pending, minimum", '0, o_minimum);
                end else begin
                    want = expected_answers.pop_front();
                    if (o_minimum !== want.minimum) begin
                        log_mismatch("minimum", want.minimum, o_minimum);
                    end
                    if (o_range_error !== want.range_error) begin
                        log_mismatch("range_error", DATA_W'(want.range_error),
                                     DATA_W'(o_range_error));
                    end
                end
            end
            if (start && !busy) begin
                update_range_minima(i_kind, i_value, int'(i_left), int'(i_right));
            end
        end
    end

    // Sends one beat, with a random idle gap ahead of it, and waits until the
    // block takes it.
    task automatic issue_beat(input logic [KIND_W-1:0] kind,
                              input logic signed [DATA_W-1:0] value,
                              input logic [9:0] left, input logic [9:0] right);
        int gap;
        if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
            gap = $urandom_range(1, 5);
            @(negedge i_clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        start   <= 1'b1;
        i_kind  <= kind;
        i_value <= value;
        i_left  <= left;
        i_right <= right;
        do @(posedge i_clk); while (busy);
        if (kind == KIND_APPEND && issued_count < MAX_ELEMENTS) issued_count++;
        if (kind == KIND_CLEAR) issued_count = 0;
    endtask

    // Holds the sender off until every pending answer has come back.
    task automatic wait_for_answers();
        @(negedge i_clk);
        start <= 1'b0;
        while (expected_answers.size() != 0) @(negedge i_clk);
        repeat (LEVELS + 2) @(negedge i_clk);
    endtask

    function automatic logic signed [DATA_W-1:0] pick_value();
        logic signed [DATA_W-1:0] v;
        case ($urandom_range(7))
            0: v = MOST_NEGATIVE;
            1: v = MOST_POSITIVE;
            2: v = '0;
            3: v = -64'sd1;
            4: begin
                v = DATA_W'($urandom_range(20));
                v = v - 64'sd10;
            end
            default: v = {$urandom, $urandom};
        endcase
        return v;
    endfunction

    // Mostly legal ranges over the stored values, sometimes anything at all.
    task automatic send_query();
        logic [9:0] left;
        logic [9:0] right;
        if (issued_count > 0 && $urandom_range(99) < 80) begin
            right = 10'($urandom_range(issued_count - 1));
            case ($urandom_range(3))
                0: left = right;
                1: left = '0;
                default: left = 10'($urandom_range(right));
            endcase
        end else begin
            left  = 10'($urandom_range(1023));
            right = 10'($urandom_range(1023));
        end
        issue_beat(KIND_QUERY, pick_value(), left, right);
    endtask

    task automatic send_append();
        issue_beat(KIND_APPEND, pick_value(), 10'($urandom_range(1023)),
                   10'($urandom_range(1023)));
    endtask

    // Extreme values, every kind, and each bad-range flavor.
    task automatic test_corner_cases();
        idle_pct = 0;
        issue_beat(KIND_QUERY, '0, 10'd0, 10'd0);
        issue_beat(KIND_APPEND, MOST_NEGATIVE, 10'd0, 10'd0);
        issue_beat(KIND_APPEND, MOST_POSITIVE, 10'h3FF, 10'h3FF);
        issue_beat(KIND_APPEND, 64'sd0, 10'd0, 10'd0);
        issue_beat(KIND_APPEND, -64'sd1, 10'd0, 10'd0);
        issue_beat(KIND_APPEND, 64'sd5, 10'd0, 10'd0);
        issue_beat(KIND_QUERY, -64'sd1, 10'd0, 10'd4);
        issue_beat(KIND_QUERY, '0, 10'd1, 10'd4);
        issue_beat(KIND_QUERY, '0, 10'd1, 10'd1);
        issue_beat(KIND_QUERY, '0, 10'd2, 10'd3);
        issue_beat(KIND_QUERY, '0, 10'd3, 10'd2);
        issue_beat(KIND_QUERY, '0, 10'd0, 10'd5);
        issue_beat(KIND_QUERY, '0, 10'h3FF, 10'h3FF);
        issue_beat(KIND_UNUSED, MOST_NEGATIVE, 10'd0, 10'd0);
        issue_beat(KIND_QUERY, '0, 10'd4, 10'd4);
        issue_beat(KIND_CLEAR, '0, 10'd0, 10'd0);
        issue_beat(KIND_QUERY, '0, 10'd0, 10'd0);
        issue_beat(KIND_APPEND, 64'sd7, 10'd0, 10'd0);
        issue_beat(KIND_APPEND, -64'sd3, 10'd0, 10'd0);
        issue_beat(KIND_QUERY, '0, 10'd0, 10'd1);
        issue_beat(KIND_QUERY, '0, 10'd0, 10'd0);
        issue_beat(KIND_APPEND, MOST_POSITIVE, 10'd0, 10'd0);
        issue_beat(KIND_QUERY, '0, 10'd0, 10'd2);
        issue_beat(KIND_QUERY, '0, 10'h200, 10'h3FF);
        wait_for_answers();
    endtask

    // Random appends, queries, clears and unused beats at a given idle rate.
    task automatic test_mixed_traffic(input int sender_idle_pct, input int beats);
        int roll;
        idle_pct = sender_idle_pct;
        issue_beat(KIND_CLEAR, pick_value(), 10'($urandom_range(1023)),
                   10'($urandom_range(1023)));
        for (int n = 0; n < beats; n++) begin
            roll = $urandom_range(99);
            if (roll < 46) begin
                send_append();
            end else if (roll < 94) begin
                send_query();
            end else if (roll < 96) begin
                issue_beat(KIND_CLEAR, pick_value(), 10'($urandom_range(1023)),
                           10'($urandom_range(1023)));
            end else if (roll < 98) begin
                issue_beat(KIND_UNUSED, pick_value(), 10'($urandom_range(1023)),
                           10'($urandom_range(1023)));
            end else begin
                wait_for_answers();
            end
        end
        wait_for_answers();
    endtask

    // Fills every position, checks that further appends are dropped, and
    // queries across the whole store so the top levels are used.
    task automatic test_full_store();
        idle_pct = 34;
        issue_beat(KIND_CLEAR, '0, 10'd0, 10'd0);
        for (int n = 0; n < MAX_ELEMENTS; n++) begin
            send_append();
            if (n % 64 == 63) send_query();
        end
        repeat (3) send_append();
        issue_beat(KIND_QUERY, '0, 10'd0, 10'h3FF);
        issue_beat(KIND_QUERY, '0, 10'd0, 10'h3FE);
        issue_beat(KIND_QUERY, '0, 10'd1, 10'h3FF);
        issue_beat(KIND_QUERY, '0, 10'h200, 10'h3FF);
        issue_beat(KIND_QUERY, '0, 10'h3FF, 10'h3FF);
        repeat (10) send_query();
        wait_for_answers();
    endtask

    initial begin
        i_rst_n = 1'b0;
        start   = 1'b0;
        i_kind  = KIND_APPEND;
        i_value = '0;
        i_left  = '0;
        i_right = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_corner_cases();
        test_mixed_traffic(0, 25);
        test_mixed_traffic(57, 25);
        test_full_store();

        // Drain and let any last table walk finish.
        wait_for_answers();
        repeat (LEVELS + 4) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

### files.f
rtl/srmu_pkg.sv
rtl/srmu_ram.sv
rtl/sparse_table_range_minimum_unit.sv
sim/testbench.sv
